### design/bamf_pkg.sv
// Shared types, constants and state codes of the max-flow engine.
package bamf_pkg;

    // Default sizing
    localparam int DEF_VERTICES   = 128;
    localparam int DEF_MAX_DEGREE = 128;
    localparam int DEF_CAP_BITS   = 16;

    // Fixed field widths
    localparam int VID_W    = 7;
    localparam int CAP_IN_W = 16;
    localparam int FLOW_W   = 32;

    // Item modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_SOLVE = 2'd2;

    // Configuration register indexes
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_SINK   = 1'b1;

    // One input item, last field in the low bits
    typedef struct packed {
        logic [CAP_IN_W-1:0] edge_capacity;
        logic [VID_W-1:0]    edge_to;
        logic [VID_W-1:0]    edge_from;
        logic [1:0]          mode;
    } item_t;

    // One result item
    typedef struct packed {
        logic [FLOW_W-1:0] total_flow;
        logic              status;
    } result_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD0,
        ST_ADD1,
        ST_ADD2,
        ST_ADD3,
        ST_ADD4,
        SR_INIT,
        SR_POP,
        SR_X,
        SR_D,
        SR_NB,
        SR_Y,
        SR_C,
        AU_D,
        AU_D2,
        AU_NB,
        AU_U,
        AU_UC,
        WK_1,
        WK_2,
        WK_3,
        RM_R1,
        RM_W1,
        RM_R2,
        RM_W2,
        AP_NEXT,
        AP_P,
        ST_DONE
    } state_t;

endpackage

### design/bamf_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module bamf_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/bamf_ctrl.sv
// Sequencer: graph loading, clearing sweep, breadth-first search and augmenting.
module bamf_ctrl
    import bamf_pkg::*;
#(
    parameter int VERTICES   = DEF_VERTICES,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int CAP_BITS   = DEF_CAP_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    input  logic [VID_W-1:0] source_vertex,
    input  logic [VID_W-1:0] sink_vertex,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam int VB  = $clog2(VERTICES);
    localparam int QB  = $clog2(VERTICES + 1);
    localparam int DB  = $clog2(MAX_DEGREE + 1);
    localparam int CAW = $clog2(VERTICES * VERTICES);
    localparam int NAW = $clog2(VERTICES * MAX_DEGREE);
    localparam logic [CAP_BITS-1:0] CAP_MAX = '1;

    state_t state_reg, state_next;

    logic [1:0]          mode_reg, mode_next;
    logic [VB-1:0]       a_reg, a_next, b_reg, b_next;
    logic [CAP_BITS-1:0] c_reg, c_next;
    logic [DB-1:0]       da_reg, da_next, db_reg, db_next;
    logic [CAW-1:0]      clr_reg, clr_next;
    logic                pend_reg, pend_next;
    logic [QB-1:0]       head_reg, head_next, tail_reg, tail_next;
    logic [QB-1:0]       steps_reg, steps_next;
    logic [VB-1:0]       x_reg, x_next, y_reg, y_next, u_reg, u_next;
    logic [VB-1:0]       ra_reg, ra_next, rb_reg, rb_next;
    logic [VB-1:0]       src_reg, src_next, snk_reg, snk_next;
    logic [DB-1:0]       d_reg, d_next, z_reg, z_next;
    logic [CAP_BITS-1:0] add_reg, add_next;
    logic [FLOW_W-1:0]   total_reg, total_next;
    logic                status_reg, status_next;
    logic [VERTICES-1:0] reached_reg, reached_next;

    // Memory ports
    logic                cap_we;
    logic [CAW-1:0]      cap_waddr, cap_raddr;
    logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
    logic                nbr_we;
    logic [NAW-1:0]      nbr_waddr, nbr_raddr;
    logic [VB-1:0]       nbr_wdata, nbr_rdata;
    logic                deg_we;
    logic [VB-1:0]       deg_waddr, deg_raddr;
    logic [DB-1:0]       deg_wdata, deg_rdata;
    logic                pred_we;
    logic [VB-1:0]       pred_waddr, pred_raddr, pred_wdata, pred_rdata;
    logic                q_we;
    logic [VB-1:0]       q_waddr, q_raddr, q_wdata, q_rdata;

    // Helper arithmetic
    logic                add_ok;
    logic [DB-1:0]       dbe;
    logic [CAP_BITS:0]   cap_sum;
    logic [FLOW_W:0]     flow_sum;
    logic                in_range;
    logic                solve_ok;

    function automatic logic [CAW-1:0] cap_addr(input logic [VB-1:0] r,
                                                input logic [VB-1:0] c);
        cap_addr = CAW'(r) * CAW'(VERTICES) + CAW'(c);
    endfunction

    function automatic logic [NAW-1:0] nbr_addr(input logic [VB-1:0] r,
                                                input logic [DB-1:0] c);
        nbr_addr = NAW'(r) * NAW'(MAX_DEGREE) + NAW'(c);
    endfunction

    bamf_ram #(.DEPTH(VERTICES * VERTICES), .WIDTH(CAP_BITS)) u_cap (
        .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
        .raddr(cap_raddr), .rdata(cap_rdata)
    );

    bamf_ram #(.DEPTH(VERTICES * MAX_DEGREE), .WIDTH(VB)) u_nbr (
        .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
        .raddr(nbr_raddr), .rdata(nbr_rdata)
    );

    bamf_ram #(.DEPTH(VERTICES), .WIDTH(DB)) u_deg (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    bamf_ram #(.DEPTH(VERTICES), .WIDTH(VB)) u_pred (
        .clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
        .raddr(pred_raddr), .rdata(pred_rdata)
    );

    bamf_ram #(.DEPTH(VERTICES), .WIDTH(VB)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // Side computations
    assign in_range = (32'(item.edge_from) < 32'(VERTICES))
                   && (32'(item.edge_to) < 32'(VERTICES));
    assign solve_ok = (32'(source_vertex) < 32'(VERTICES))
                   && (32'(sink_vertex) < 32'(VERTICES))
                   && (source_vertex != sink_vertex);
    assign add_ok   = (a_reg == b_reg)
                    ? (32'(da_reg) + 32'd2 <= 32'(MAX_DEGREE))
                    : ((32'(da_reg) < 32'(MAX_DEGREE)) && (32'(deg_rdata) < 32'(MAX_DEGREE)));
    assign dbe      = (a_reg == b_reg) ? (da_reg + DB'(1)) : db_reg;
    assign cap_sum  = {1'b0, cap_rdata} + {1'b0, add_reg};
    assign flow_sum = {1'b0, total_reg} + (FLOW_W + 1)'(add_reg);

    assign res.status     = status_reg;
    assign res.total_flow = total_reg;

    // State and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            reached_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            reached_reg <= reached_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        steps_reg  <= steps_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        u_reg      <= u_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        src_reg    <= src_next;
        snk_reg    <= snk_next;
        d_reg      <= d_next;
        z_reg      <= z_next;
        add_reg    <= add_next;
        total_reg  <= total_next;
        status_reg <= status_next;
    end

    // Next state, memory control and outputs
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        da_next      = da_reg;
        db_next      = db_reg;
        clr_next     = clr_reg;
        pend_next    = pend_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        steps_next   = steps_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        u_next       = u_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        src_next     = src_reg;
        snk_next     = snk_reg;
        d_next       = d_reg;
        z_next       = z_reg;
        add_next     = add_reg;
        total_next   = total_reg;
        status_next  = status_reg;
        reached_next = reached_reg;

        cap_we     = 1'b0;
        cap_waddr  = '0;
        cap_wdata  = '0;
        cap_raddr  = '0;
        nbr_we     = 1'b0;
        nbr_waddr  = '0;
        nbr_wdata  = '0;
        nbr_raddr  = '0;
        deg_we     = 1'b0;
        deg_waddr  = '0;
        deg_wdata  = '0;
        deg_raddr  = '0;
        pred_we    = 1'b0;
        pred_waddr = '0;
        pred_wdata = '0;
        pred_raddr = '0;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        q_raddr    = '0;

        item_ready = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            // Zero the capacity matrix and degrees, one entry a cycle
            ST_CLEAR:
            begin
                cap_we    = 1'b1;
                cap_waddr = clr_reg;
                if (clr_reg < CAW'(VERTICES))
                begin
                    deg_we    = 1'b1;
                    deg_waddr = clr_reg[VB-1:0];
                end
                clr_next = clr_reg + CAW'(1);
                if (clr_reg == CAW'(VERTICES * VERTICES - 1))
                begin
                    clr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    mode_next   = item.mode;
                    a_next      = VB'(item.edge_from);
                    b_next      = VB'(item.edge_to);
                    c_next      = CAP_BITS'(item.edge_capacity);
                    status_next = 1'b0;
                    total_next  = '0;
                    src_next    = VB'(source_vertex);
                    snk_next    = VB'(sink_vertex);
                    case (item.mode)
                        MODE_ADD:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_ADD0;
                            end
                            else
                            begin
                                status_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            clr_next   = '0;
                            pend_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        MODE_SOLVE:
                        begin
                            state_next = solve_ok ? SR_INIT : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Edge loading: fetch both degrees, check room, append
            ST_ADD0:
            begin
                deg_raddr  = a_reg;
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                deg_raddr  = b_reg;
                da_next    = deg_rdata;
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                db_next = deg_rdata;
                if (add_ok)
                begin
                    state_next = ST_ADD3;
                end
                else
                begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_ADD3:
            begin
                cap_we     = 1'b1;
                cap_waddr  = cap_addr(a_reg, b_reg);
                cap_wdata  = c_reg;
                nbr_we     = 1'b1;
                nbr_waddr  = nbr_addr(a_reg, da_reg);
                nbr_wdata  = b_reg;
                deg_we     = 1'b1;
                deg_waddr  = a_reg;
                deg_wdata  = da_reg + DB'(1);
                state_next = ST_ADD4;
            end
            ST_ADD4:
            begin
                nbr_we     = 1'b1;
                nbr_waddr  = nbr_addr(b_reg, dbe);
                nbr_wdata  = a_reg;
                deg_we     = 1'b1;
                deg_waddr  = b_reg;
                deg_wdata  = dbe + DB'(1);
                state_next = ST_DONE;
            end

            // Search: seed the queue with the source
            SR_INIT:
            begin
                reached_next          = '0;
                reached_next[src_reg] = 1'b1;
                pred_we               = 1'b1;
                pred_waddr            = src_reg;
                pred_wdata            = src_reg;
                q_we                  = 1'b1;
                q_waddr               = '0;
                q_wdata               = src_reg;
                head_next             = '0;
                tail_next             = QB'(1);
                state_next            = SR_POP;
            end
            SR_POP:
            begin
                if (head_reg < tail_reg && !reached_reg[snk_reg])
                begin
                    q_raddr    = head_reg[VB-1:0];
                    head_next  = head_reg + QB'(1);
                    state_next = SR_X;
                end
                else if (reached_reg[snk_reg])
                begin
                    state_next = AU_D;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            SR_X:
            begin
                x_next     = q_rdata;
                deg_raddr  = q_rdata;
                state_next = SR_D;
            end
            SR_D:
            begin
                d_next     = deg_rdata;
                z_next     = '0;
                state_next = SR_NB;
            end
            SR_NB:
            begin
                if (z_reg < d_reg)
                begin
                    nbr_raddr  = nbr_addr(x_reg, z_reg);
                    state_next = SR_Y;
                end
                else
                begin
                    state_next = SR_POP;
                end
            end
            SR_Y:
            begin
                y_next     = nbr_rdata;
                cap_raddr  = cap_addr(x_reg, nbr_rdata);
                state_next = SR_C;
            end
            SR_C:
            begin
                if (!reached_reg[y_reg] && cap_rdata != '0 && tail_reg < QB'(VERTICES))
                begin
                    reached_next[y_reg] = 1'b1;
                    pred_we             = 1'b1;
                    pred_waddr          = y_reg;
                    pred_wdata          = x_reg;
                    q_we                = 1'b1;
                    q_waddr             = tail_reg[VB-1:0];
                    q_wdata             = y_reg;
                    tail_next           = tail_reg + QB'(1);
                end
                z_next     = z_reg + DB'(1);
                state_next = SR_NB;
            end

            // Augment: scan the sink's neighbours
            AU_D:
            begin
                deg_raddr  = snk_reg;
                state_next = AU_D2;
            end
            AU_D2:
            begin
                d_next     = deg_rdata;
                z_next     = '0;
                state_next = AU_NB;
            end
            AU_NB:
            begin
                if (z_reg < d_reg)
                begin
                    nbr_raddr  = nbr_addr(snk_reg, z_reg);
                    state_next = AU_U;
                end
                else
                begin
                    state_next = SR_INIT;
                end
            end
            AU_U:
            begin
                u_next = nbr_rdata;
                if (reached_reg[nbr_rdata])
                begin
                    cap_raddr  = cap_addr(nbr_rdata, snk_reg);
                    state_next = AU_UC;
                end
                else
                begin
                    z_next     = z_reg + DB'(1);
                    state_next = AU_NB;
                end
            end
            AU_UC:
            begin
                if (cap_rdata == '0)
                begin
                    z_next     = z_reg + DB'(1);
                    state_next = AU_NB;
                end
                else
                begin
                    add_next   = cap_rdata;
                    x_next     = u_reg;
                    steps_next = '0;
                    state_next = WK_1;
                end
            end

            // Walk the tree path for the bottleneck
            WK_1:
            begin
                if (x_reg == src_reg || steps_reg == QB'(VERTICES))
                begin
                    if (add_reg == '0)
                    begin
                        z_next     = z_reg + DB'(1);
                        state_next = AU_NB;
                    end
                    else
                    begin
                        ra_next    = u_reg;
                        rb_next    = snk_reg;
                        x_next     = u_reg;
                        steps_next = '0;
                        state_next = RM_R1;
                    end
                end
                else
                begin
                    pred_raddr = x_reg;
                    state_next = WK_2;
                end
            end
            WK_2:
            begin
                ra_next    = pred_rdata;
                cap_raddr  = cap_addr(pred_rdata, x_reg);
                state_next = WK_3;
            end
            WK_3:
            begin
                if (cap_rdata < add_reg)
                begin
                    add_next = cap_rdata;
                end
                x_next     = ra_reg;
                steps_next = steps_reg + QB'(1);
                state_next = WK_1;
            end

            // Read-modify-write of one edge pair: forward minus, reverse plus
            RM_R1:
            begin
                cap_raddr  = cap_addr(ra_reg, rb_reg);
                state_next = RM_W1;
            end
            RM_W1:
            begin
                cap_we     = 1'b1;
                cap_waddr  = cap_addr(ra_reg, rb_reg);
                cap_wdata  = cap_rdata - add_reg;
                state_next = RM_R2;
            end
            RM_R2:
            begin
                cap_raddr  = cap_addr(rb_reg, ra_reg);
                state_next = RM_W2;
            end
            RM_W2:
            begin
                cap_we     = 1'b1;
                cap_waddr  = cap_addr(rb_reg, ra_reg);
                cap_wdata  = cap_sum[CAP_BITS] ? CAP_MAX : cap_sum[CAP_BITS-1:0];
                state_next = AP_NEXT;
            end
            AP_NEXT:
            begin
                if (x_reg == src_reg || steps_reg == QB'(VERTICES))
                begin
                    total_next = flow_sum[FLOW_W] ? '1 : flow_sum[FLOW_W-1:0];
                    z_next     = z_reg + DB'(1);
                    state_next = AU_NB;
                end
                else
                begin
                    pred_raddr = x_reg;
                    state_next = AP_P;
                end
            end
            AP_P:
            begin
                ra_next    = pred_rdata;
                rb_next    = x_reg;
                x_next     = pred_rdata;
                steps_next = steps_reg + QB'(1);
                state_next = RM_R1;
            end

            // Hand the result over
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/bfs_augmenting_max_flow.sv
// Top level of the max-flow engine: stream ports, configuration registers, output register.
//
// Items are taken one at a time. An add-edge item passes from the accepting
// state through two degree reads, a room check, two write steps and the
// hand-off state before the next beat is taken. A clear item sweeps the
// capacity matrix, VERTICES*VERTICES entries (16384 by default), one entry a
// cycle; the same sweep runs after reset, and no item is accepted until it
// ends. A solve item runs as long as the graph demands: each search visits
// every neighbour-list entry of every vertex taken off the queue, and each
// augmenting path is walked edge by edge once to find its bottleneck and
// once more to update it, all bound by the single read port of the capacity
// memory. The result then waits in an output register while the next item
// is taken.
module bfs_augmenting_max_flow
    import bamf_pkg::*;
#(
    parameter int VERTICES   = DEF_VERTICES,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int CAP_BITS   = DEF_CAP_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    // Input beats: [1:0] mode, [8:2] edge_from, [15:9] edge_to, [31:16] edge_capacity
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,
    // Result beats: [0] status, [32:1] total_flow, [39:33] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,
    // Configuration writes
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [VID_W-1:0] cfg_wdata
);

    logic [VID_W-1:0] source_reg;
    logic [VID_W-1:0] sink_reg;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic             out_valid_reg;
    result_t          out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= '0;
            sink_reg   <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE: source_reg <= cfg_wdata;
                REG_SINK:   sink_reg   <= cfg_wdata;
                default:    source_reg <= source_reg;
            endcase
        end
    end

    bamf_ctrl #(
        .VERTICES(VERTICES),
        .MAX_DEGREE(MAX_DEGREE),
        .CAP_BITS(CAP_BITS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(s_tvalid),
        .item_ready(s_tready),
        .item(item_t'(s_tdata)),
        .source_vertex(source_reg),
        .sink_vertex(sink_reg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg};

endmodule

### verif/tb_top.sv
// Testbench for the max-flow engine: directed and random edge loading, clears and solves.
module tb_top
    import bamf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 128;
    localparam int ND = 128;
    localparam logic [15:0] CAPMAX = 16'hFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_SOURCE;
    logic [6:0]  cfg_wdata = '0;

    bfs_augmenting_max_flow u_dut (.*);

    always #4 clk = ~clk;

    // Graph mirror
    logic [15:0] res_cap [NV*NV];
    logic [6:0]  nbr [NV*ND];
    int          degree [NV];
    int          pred [NV];
    bit          seen [NV];
    logic [6:0]  src_v = 7'd0;
    logic [6:0]  snk_v = 7'd127;
    result_t     expected_results[$];
    int          errors = 0;
    bit          burst_on = 1'b1;
    int          burst_left = 0;

    // Breadth-first search from the source; true when the sink is reached
    function automatic bit bfs_reach();
        int q[$];
        int x, y;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[src_v] = 1'b1;
        pred[src_v] = int'(src_v);
        q = {q, int'(src_v)};
        while (q.size() > 0 && !seen[snk_v])
        begin
            x = q.pop_front();
            for (int z = 0; z < degree[x]; z++)
            begin
                y = int'(nbr[x*ND+z]);
                if (!seen[y] && res_cap[x*NV+y] > 0)
                begin
                    seen[y] = 1'b1;
                    pred[y] = x;
                    q = {q, y};
                end
            end
        end
        return seen[snk_v];
    endfunction

    function automatic void push_flow(int a, int b, logic [15:0] amt);
        logic [16:0] s;
        res_cap[a*NV+b] = res_cap[a*NV+b] - amt;
        s = {1'b0, res_cap[b*NV+a]} + {1'b0, amt};
        res_cap[b*NV+a] = s[16] ? CAPMAX : s[15:0];
    endfunction

    function automatic logic [31:0] solve_flow();
        longint total = 0;
        int u, x, p, steps;
        logic [15:0] amt;
        while (bfs_reach())
        begin
            for (int z = 0; z < degree[snk_v]; z++)
            begin
                u = int'(nbr[snk_v*ND+z]);
                if (!seen[u] || res_cap[u*NV+snk_v] == 0) continue;
                amt = res_cap[u*NV+snk_v];
                x = u;
                for (steps = 0; x != src_v && steps < NV; steps++)
                begin
                    p = pred[x];
                    if (res_cap[p*NV+x] < amt) amt = res_cap[p*NV+x];
                    x = p;
                end
                if (amt == 0) continue;
                push_flow(u, int'(snk_v), amt);
                x = u;
                for (steps = 0; x != src_v && steps < NV; steps++)
                begin
                    p = pred[x];
                    push_flow(p, x, amt);
                    x = p;
                end
                total += longint'(amt);
                if (total > longint'(32'hFFFF_FFFF)) total = longint'(32'hFFFF_FFFF);
            end
        end
        return total[31:0];
    endfunction

    // Expected result of one accepted item
    function automatic result_t predict_result(item_t it);
        result_t r;
        bit ok;
        int a, b;
        r = '0;
        a = int'(it.edge_from);
        b = int'(it.edge_to);
        case (it.mode)
            MODE_ADD:
            begin
                if (a == b) ok = degree[a] + 2 <= ND;
                else ok = degree[a] < ND && degree[b] < ND;
                if (ok)
                begin
                    res_cap[a*NV+b] = it.edge_capacity;
                    nbr[a*ND+degree[a]] = b[6:0];
                    degree[a]++;
                    nbr[b*ND+degree[b]] = a[6:0];
                    degree[b]++;
                end
                else r.status = 1'b1;
            end
            MODE_CLEAR:
            begin
                foreach (res_cap[i]) res_cap[i] = '0;
                foreach (degree[i]) degree[i] = 0;
            end
            MODE_SOLVE:
            begin
                if (src_v != snk_v) r.total_flow = solve_flow();
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one beat, bursts with random gaps
    task automatic send_item(logic [1:0] mode, logic [6:0] a, logic [6:0] b, logic [15:0] c);
        item_t it;
        int gap;
        it = '{edge_capacity: c, edge_to: b, edge_from: a, mode: mode};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) * $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= it;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_results = {expected_results, predict_result(it)};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SOURCE) src_v = val;
        else snk_v = val;
    endtask

    // Receiver stall pattern
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 15) < 11) || burst_on;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[32:0];
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", m_tdata);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status || got.total_flow !== exp_r.total_flow
                    || m_tdata[39:33] !== '0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp status %0d flow %0d, got status %0d flow %0d",
                                 exp_r.status, exp_r.total_flow, got.status, got.total_flow);
                end
            end
        end
    end

    task automatic test_directed();
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        send_item(MODE_ADD, 7'd0, 7'd127, 16'hFFFF);
        send_item(MODE_ADD, 7'd127, 7'd0, 16'h0000);
        send_item(MODE_ADD, 7'd5, 7'd5, 16'h1234);
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        send_item(2'd3, 7'h7F, 7'h7F, 16'hFFFF);
        send_item(MODE_CLEAR, 7'd0, 7'd0, 16'd0);
        // two parallel paths, the first saturating a reverse edge
        send_item(MODE_ADD, 7'd0, 7'd1, 16'hFFFF);
        send_item(MODE_ADD, 7'd1, 7'd127, 16'hFFFF);
        send_item(MODE_ADD, 7'd127, 7'd1, 16'h0001);
        send_item(MODE_ADD, 7'd0, 7'd2, 16'h8000);
        send_item(MODE_ADD, 7'd2, 7'd127, 16'hAAAA);
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        write_reg(REG_SINK, 7'd0);
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        write_reg(REG_SOURCE, 7'd127);
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        send_item(MODE_CLEAR, 7'd0, 7'd0, 16'd0);
    endtask

    // Fill one neighbour list to its limit
    task automatic test_full_list();
        write_reg(REG_SOURCE, 7'd0);
        write_reg(REG_SINK, 7'd127);
        for (int i = 0; i < ND + 2; i++)
            send_item(MODE_ADD, 7'd9, 7'(i), 16'($urandom_range(0, 65535)));
        send_item(MODE_ADD, 7'd9, 7'd9, 16'd1);
        send_item(MODE_ADD, 7'd10, 7'd10, 16'd1);
        send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
        send_item(MODE_CLEAR, 7'd0, 7'd0, 16'd0);
    endtask

    // Random small graphs on a few vertices, each ended by a solve and a clear
    task automatic test_random(int n_items);
        int sent = 0;
        int span;
        logic [6:0] base;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_SOURCE, 7'($urandom_range(0, 127)));
                write_reg(REG_SINK, ($urandom_range(0, 3) == 0) ? src_v
                                                               : 7'($urandom_range(0, 127)));
            end
            burst_on = 1'($urandom_range(0, 1));
            span = $urandom_range(3, 10);
            base = 7'($urandom_range(0, 127 - span));
            repeat ($urandom_range(4, 20))
            begin
                case ($urandom_range(0, 19))
                    0: send_item(2'd3, 7'($urandom), 7'($urandom), 16'($urandom));
                    1: send_item(MODE_ADD, 7'($urandom), 7'($urandom), 16'($urandom));
                    default: send_item(MODE_ADD,
                        ($urandom_range(0, 4) == 0) ? src_v : base + 7'($urandom_range(0, span)),
                        ($urandom_range(0, 4) == 0) ? snk_v : base + 7'($urandom_range(0, span)),
                        ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
                endcase
                sent++;
            end
            send_item(MODE_SOLVE, 7'($urandom), 7'($urandom), 16'($urandom));
            if ($urandom_range(0, 1)) send_item(MODE_SOLVE, 7'd0, 7'd0, 16'd0);
            send_item(MODE_CLEAR, 7'($urandom), 7'($urandom), 16'($urandom));
            sent += 2;
            if ($urandom_range(0, 4) == 0) drain();
        end
    endtask

    initial
    begin
        foreach (res_cap[i]) res_cap[i] = '0;
        foreach (nbr[i]) nbr[i] = '0;
        foreach (degree[i]) degree[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_list();
        test_random(540);
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("bfs_augmenting_max_flow verification clean");
        else
            $display("bfs_augmenting_max_flow verification failed");
        $finish;
    end

    // Timeout guard: clears dominate, each sweeping the whole capacity matrix
    initial
    begin
        #400ms;
        $display("bfs_augmenting_max_flow verification failed");
        $finish;
    end
endmodule

### bfs_augmenting_max_flow.f
design/bamf_pkg.sv
design/bamf_ram.sv
design/bamf_ctrl.sv
design/bfs_augmenting_max_flow.sv
verif/tb_top.sv
